FILE: rtl/core/stli_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stli_pkg
// shared types and codes for the sorted table linear interpolator
// ----------------------------------------------------------------------------
package stli_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_SORT   = 2'd1,
    MODE_INTERP = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] CFG_KEY_COLUMN     = 2'd0;
  localparam logic [1:0] CFG_ROWS_IN_USE    = 2'd1;
  localparam logic [1:0] CFG_COLUMNS_IN_USE = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         row;
    logic [2:0]         column;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/stli_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stli_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module stli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/sorted_table_linear_interpolator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_top
// table of signed fixed-point cells with write, read, row sort and
// piecewise linear interpolation along a key column
// ----------------------------------------------------------------------------
// One item at a time through a single-port table RAM (one cell access per
// cycle) and a sequencer. A sort compares key pairs and swaps all
// MAX_COLUMNS cells of each out-of-order row pair, so it is quadratic in
// rows in use. An interpolation checks the end keys, scans row pairs, then
// reads an end row's value, or for a bracketing pair reads the two values,
// runs a shift-add multiply and a restoring divide (one quotient bit per
// cycle) and forms the result. in_stall is high from acceptance until the
// result is taken. No clearing pass.
module sorted_table_linear_interpolator_top
  import stli_pkg::*;
#(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_wdata
);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int AW = RW + CW;
  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * VW;
  localparam int NW = RW + 1;
  localparam int CNW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_LAT, S_RD_GET,
    S_SO_RA, S_SO_RB, S_SO_LAT, S_SO_CMP, S_SO_SW_RA, S_SO_SW_RB,
    S_SO_SW_LAT, S_SO_SW_WA, S_SO_SW_WB, S_SO_NEXT,
    S_IP_EDGE, S_IP_LAT, S_IP_CHK, S_IP_SCAN, S_IP_SLAT, S_IP_SCMP,
    S_IP_Y, S_IP_YLAT, S_IP_MUL, S_IP_DIV, S_IP_FIN, S_OUT
  } state_t;

  state_t            state_r;
  logic [2:0]        key_r;
  logic [8:0]        rows_r;
  logic [3:0]        cols_r;
  in_item_t          item_r;
  out_item_t         out_r;
  logic [NW-1:0]     n_r, i_r, pass_r;
  logic [CW-1:0]     k_r, c_r;
  logic [1:0]        sub_r;
  logic signed [VW-1:0] a_r, b_r, x_r, k0_r, y0_r, t_r;
  logic [VW-1:0]     mag_r, dx_r, den_r;
  logic [PW-1:0]     prod_r, quo_r;
  logic [VW:0]       rem_r;
  logic [$clog2(PW+1)-1:0] cnt_r;
  logic              neg_r;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [VW-1:0]     ram_wdata, ram_rdata;

  stli_ram #(.WIDTH(VW), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // effective sizes
  logic [NW-1:0]  eff_rows;
  logic [CNW-1:0] eff_cols;
  logic [CW-1:0]  eff_key;
  always_comb begin
    eff_rows = (32'(rows_r) > 32'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(rows_r);
    eff_cols = (32'(cols_r) > 32'(MAX_COLUMNS)) ? CNW'(MAX_COLUMNS) : CNW'(cols_r);
    eff_key  = (32'(key_r) < 32'(eff_cols)) ? CW'(key_r) : '0;
  end

  function automatic logic [AW-1:0] cell_addr(input logic [NW-1:0] r, input logic [CW-1:0] c);
    return {r[RW-1:0], c};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [VW+32:0] w;
    w = (VW+33)'(v);
    if (w > (VW+33)'(64'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (w < -(VW+33)'(64'sh80000000)) return 32'sh80000000;
    return 32'(v);
  endfunction

  // ram port driven by state
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = '0;
    case (state_r)
      S_IDLE: begin
        ram_we    = in_valid && (in_data.mode == MODE_WRITE) &&
                    (32'(in_data.row) < 32'(MAX_ROWS)) &&
                    (32'(in_data.column) < 32'(MAX_COLUMNS));
        ram_addr  = {RW'(in_data.row), CW'(in_data.column)};
        ram_wdata = VW'(in_data.value);
      end
      S_RD_LAT:   ram_addr = cell_addr(NW'(item_r.row), CW'(item_r.column));
      S_SO_RA:    ram_addr = cell_addr(i_r, k_r);
      S_SO_RB:    ram_addr = cell_addr(i_r + 1'b1, k_r);
      S_SO_SW_RA: ram_addr = cell_addr(i_r, c_r);
      S_SO_SW_RB: ram_addr = cell_addr(i_r + 1'b1, c_r);
      S_SO_SW_WA: begin
        ram_we = 1'b1; ram_addr = cell_addr(i_r, c_r); ram_wdata = b_r;
      end
      S_SO_SW_WB: begin
        ram_we = 1'b1; ram_addr = cell_addr(i_r + 1'b1, c_r); ram_wdata = a_r;
      end
      S_IP_EDGE:  ram_addr = (sub_r == 2'd0) ? cell_addr('0, k_r) : cell_addr(n_r - 1'b1, k_r);
      S_IP_SCAN:  ram_addr = cell_addr(i_r + 1'b1, k_r);
      S_IP_Y:     ram_addr = (sub_r == 2'd1) ? cell_addr(i_r + 1'b1, c_r) : cell_addr(i_r, c_r);
      default: ;
    endcase
  end

  logic [VW:0] rem_sh;
  assign rem_sh = {rem_r[VW-1:0], prod_r[PW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_r   <= '0;
      rows_r  <= '0;
      cols_r  <= 4'd8;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_COLUMN:     key_r  <= cfg_wdata[2:0];
          CFG_ROWS_IN_USE:    rows_r <= cfg_wdata;
          CFG_COLUMNS_IN_USE: cols_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            n_r    <= eff_rows;
            k_r    <= eff_key;
            case (in_data.mode)
              MODE_WRITE: begin
                out_r <= '{result: '0, status: (ram_we ? ST_OK : ST_RANGE)};
                state_r <= S_OUT;
              end
              MODE_SORT: begin
                out_r <= '{result: '0, status: ST_OK};
                pass_r <= NW'(1); i_r <= '0;
                state_r <= (eff_rows > NW'(1)) ? S_SO_RA : S_OUT;
              end
              MODE_INTERP: begin
                c_r <= CW'(in_data.column);
                x_r <= VW'(in_data.value);
                sub_r <= 2'd0;
                if (eff_rows == '0) begin
                  out_r <= '{result: '0, status: ST_EMPTY}; state_r <= S_OUT;
                end else if (32'(in_data.column) >= 32'(eff_cols)) begin
                  out_r <= '{result: '0, status: ST_RANGE}; state_r <= S_OUT;
                end else begin
                  out_r <= '{result: '0, status: ST_OK}; state_r <= S_IP_EDGE;
                end
              end
              default: begin
                if (32'(in_data.row) < 32'(eff_rows) &&
                    32'(in_data.column) < 32'(eff_cols)) begin
                  out_r <= '{result: '0, status: ST_OK};
                  state_r <= S_RD_LAT;
                end else begin
                  out_r <= '{result: '0, status: ST_RANGE}; state_r <= S_OUT;
                end
              end
            endcase
          end
        end
        S_RD_LAT: state_r <= S_RD_GET;
        S_RD_GET: begin
          out_r.result <= sat32(ram_rdata);
          state_r <= S_OUT;
        end
        // sort
        S_SO_RA:  state_r <= S_SO_RB;
        S_SO_RB: begin
          a_r <= ram_rdata; state_r <= S_SO_LAT;
        end
        S_SO_LAT: begin
          b_r <= ram_rdata; state_r <= S_SO_CMP;
        end
        S_SO_CMP: begin
          c_r <= '0;
          state_r <= (b_r < a_r) ? S_SO_SW_RA : S_SO_NEXT;
        end
        S_SO_SW_RA: state_r <= S_SO_SW_RB;
        S_SO_SW_RB: begin
          a_r <= ram_rdata; state_r <= S_SO_SW_LAT;
        end
        S_SO_SW_LAT: begin
          b_r <= ram_rdata; state_r <= S_SO_SW_WA;
        end
        S_SO_SW_WA: state_r <= S_SO_SW_WB;
        S_SO_SW_WB: begin
          if (c_r == CW'(MAX_COLUMNS - 1)) state_r <= S_SO_NEXT;
          else begin
            c_r <= c_r + 1'b1; state_r <= S_SO_SW_RA;
          end
        end
        S_SO_NEXT: begin
          if (i_r + pass_r + 1'b1 < n_r) begin
            i_r <= i_r + 1'b1; state_r <= S_SO_RA;
          end else if (pass_r + 1'b1 < n_r) begin
            pass_r <= pass_r + 1'b1; i_r <= '0; state_r <= S_SO_RA;
          end else state_r <= S_OUT;
        end
        // interpolate: first and last keys
        S_IP_EDGE: begin
          if (sub_r == 2'd1) begin
            a_r <= ram_rdata; state_r <= S_IP_LAT;
          end
          sub_r <= sub_r + 1'b1;
        end
        S_IP_LAT: begin
          b_r <= ram_rdata; state_r <= S_IP_CHK;
        end
        S_IP_CHK: begin
          if (x_r < a_r) begin
            i_r <= '0; sub_r <= 2'd2; state_r <= S_IP_Y;
          end else if (b_r < x_r || n_r == NW'(1)) begin
            i_r <= n_r - 1'b1; sub_r <= 2'd2; state_r <= S_IP_Y;
          end else begin
            i_r <= '0; k0_r <= a_r; state_r <= S_IP_SCAN;
          end
        end
        S_IP_SCAN: state_r <= S_IP_SLAT;
        S_IP_SLAT: begin
          t_r <= ram_rdata; state_r <= S_IP_SCMP;
        end
        S_IP_SCMP: begin
          if (!(x_r < k0_r) && x_r < t_r) begin
            den_r <= VW'(t_r - k0_r);
            dx_r  <= VW'(x_r - k0_r);
            sub_r <= 2'd0;
            state_r <= S_IP_Y;
          end else if (i_r + NW'(2) < n_r) begin
            i_r <= i_r + 1'b1; k0_r <= t_r; state_r <= S_IP_SCAN;
          end else if (x_r == b_r) begin
            // x on the last key with no bracketing pair
            i_r <= n_r - 1'b1; sub_r <= 2'd2; state_r <= S_IP_Y;
          end else state_r <= S_OUT;
        end
        S_IP_Y: begin
          if (sub_r == 2'd0) sub_r <= 2'd1;
          else begin
            if (sub_r == 2'd1) begin
              y0_r <= ram_rdata; sub_r <= 2'd3;
            end
            state_r <= S_IP_YLAT;
          end
        end
        S_IP_YLAT: begin
          if (sub_r == 2'd2) begin
            out_r.result <= sat32(ram_rdata);
            state_r <= S_OUT;
          end else begin
            // y1 arrives; y0 was registered the cycle before
            neg_r <= $signed(ram_rdata) < y0_r;
            mag_r <= ($signed(ram_rdata) < y0_r) ? VW'(y0_r - ram_rdata) :
                                                  VW'(ram_rdata - y0_r);
            prod_r <= '0;
            cnt_r  <= '0;
            state_r <= S_IP_MUL;
          end
        end
        S_IP_MUL: begin
          prod_r <= (prod_r << 1) + (dx_r[VW-1] ? PW'(mag_r) : PW'(0));
          dx_r   <= dx_r << 1;
          if (cnt_r == ($clog2(PW+1))'(VW - 1)) begin
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= '0;
            state_r <= S_IP_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IP_DIV: begin
          prod_r <= prod_r << 1;
          if (rem_sh >= (VW+1)'(den_r)) begin
            rem_r <= rem_sh - (VW+1)'(den_r);
            quo_r <= {quo_r[PW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[PW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ($clog2(PW+1))'(PW - 1)) begin
            sub_r <= 2'd0;
            state_r <= S_IP_FIN;
          end
        end
        S_IP_FIN: begin
          out_r.result <= sat32(neg_r ? VW'(y0_r - VW'(quo_r)) : VW'(y0_r + VW'(quo_r)));
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  property p_idle_after_out;
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_stall) |=> !out_valid;
  endproperty
  a_idle_after_out: assert property (p_idle_after_out) else $error("result repeated");

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("input taken while busy");

  property p_write_only_idle;
    @(posedge clk) disable iff (!rst_n) ram_we |-> (state_r == S_IDLE || state_r == S_SO_SW_WA ||
      state_r == S_SO_SW_WB);
  endproperty
  a_write_only_idle: assert property (p_write_only_idle) else $error("stray table write");
endmodule
`default_nettype wire

FILE: test/sorted_table_linear_interpolator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_checker
// watches the input, result and register ports of the interpolator, keeps
// its own copy of the table and registers, predicts each result and compares
// it field by field with what the block returns
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_checker
  import stli_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  output int         errors,
  output int         pending
);

  logic [31:0] cells [256][8];
  logic [2:0]  key_col;
  logic [8:0]  rows_reg;
  logic [3:0]  cols_reg;
  out_item_t   expected_mem [1024];
  int          wr_cnt;
  int          rd_cnt;

  initial begin
    errors  = 0;
    pending = 0;
    wr_cnt  = 0;
    rd_cnt  = 0;
  end

  function automatic int rows_active();
    return (rows_reg > 9'd256) ? 256 : int'(rows_reg);
  endfunction

  function automatic int cols_active();
    return (cols_reg > 4'd8) ? 8 : int'(cols_reg);
  endfunction

  function automatic int key_active();
    return (int'(key_col) < cols_active()) ? int'(key_col) : 0;
  endfunction

  task automatic sort_table();
    int n;
    int k;
    logic [31:0] tmp;
    n = rows_active();
    k = key_active();
    for (int p = 1; p < n; p++) begin
      for (int j = 0; j + p < n; j++) begin
        if ($signed(cells[j+1][k]) < $signed(cells[j][k])) begin
          for (int c = 0; c < 8; c++) begin
            tmp = cells[j][c];
            cells[j][c] = cells[j+1][c];
            cells[j+1][c] = tmp;
          end
        end
      end
    end
  endtask

  function automatic logic [31:0] interpolate(logic signed [31:0] x, int col);
    int n;
    int k;
    logic signed [31:0] k0, k1, y0, y1;
    logic [63:0] mag, dx, dk, q;
    logic neg;
    n = rows_active();
    k = key_active();
    if (x < $signed(cells[0][k])) return cells[0][col];
    if ($signed(cells[n-1][k]) < x) return cells[n-1][col];
    for (int i = 0; i + 1 < n; i++) begin
      k0 = cells[i][k];
      k1 = cells[i+1][k];
      if (x >= k0 && x < k1) begin
        y0  = cells[i][col];
        y1  = cells[i+1][col];
        neg = y1 < y0;
        mag = neg ? {32'b0, 32'(y0 - y1)} : {32'b0, 32'(y1 - y0)};
        dx  = {32'b0, 32'(x - k0)};
        dk  = {32'b0, 32'(k1 - k0)};
        q   = (mag * dx) / dk;
        return neg ? 32'(y0 - q[31:0]) : 32'(y0 + q[31:0]);
      end
    end
    if (x == $signed(cells[n-1][k])) return cells[n-1][col];
    return 32'd0;
  endfunction

  task automatic predict_result(input in_item_t it, output out_item_t o);
    o.result = '0;
    o.status = ST_OK;
    case (it.mode)
      MODE_WRITE: begin
        cells[it.row][it.column] = it.value;
      end
      MODE_SORT: begin
        sort_table();
      end
      MODE_INTERP: begin
        if (rows_active() == 0) o.status = ST_EMPTY;
        else if (int'(it.column) >= cols_active()) o.status = ST_RANGE;
        else o.result = interpolate(it.value, int'(it.column));
      end
      default: begin
        if (int'(it.row) < rows_active() && int'(it.column) < cols_active())
          o.result = cells[it.row][it.column];
        else
          o.status = ST_RANGE;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t exp_item;
    out_item_t pred;
    if (!rst_n) begin
      key_col  <= 3'd0;
      rows_reg <= 9'd0;
      cols_reg <= 4'd8;
      wr_cnt   = 0;
      rd_cnt   = 0;
      pending  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (wr_cnt == rd_cnt) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result transfer: result %0d status %0d",
                                     out_data.result, out_data.status);
        end else begin
          exp_item = expected_mem[rd_cnt % 1024];
          rd_cnt = rd_cnt + 1;
          if (exp_item.result !== out_data.result || exp_item.status !== out_data.status) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("mismatch: expected result %0d status %0d, got result %0d status %0d",
                       exp_item.result, exp_item.status, out_data.result, out_data.status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_result(in_data, pred);
        expected_mem[wr_cnt % 1024] = pred;
        wr_cnt = wr_cnt + 1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_COLUMN:     key_col  <= cfg_wdata[2:0];
          CFG_ROWS_IN_USE:    rows_reg <= cfg_wdata;
          CFG_COLUMNS_IN_USE: cols_reg <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      pending <= wr_cnt - rd_cnt;
    end
  end

endmodule

FILE: test/sorted_table_linear_interpolator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_top_tb
// drives writes, reads, sorts and interpolations into the table block over
// several register settings, with random gaps and stalls on both sides, and
// reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_top_tb;
  import stli_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;
  int         errors;
  int         pending;

  int          cycles;
  int          sent;
  bit          burst;
  bit          hold_req;
  bit          written [256][8];
  logic [31:0] shadow [256][8];
  logic [2:0]  cur_key;
  logic [8:0]  cur_rows;
  logic [3:0]  cur_cols;

  sorted_table_linear_interpolator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  sorted_table_linear_interpolator_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int rows_active();
    return (cur_rows > 9'd256) ? 256 : int'(cur_rows);
  endfunction

  function automatic int cols_active();
    return (cur_cols > 4'd8) ? 8 : int'(cur_cols);
  endfunction

  function automatic int key_active();
    return (int'(cur_key) < cols_active()) ? int'(cur_key) : 0;
  endfunction

  function automatic bit can_read(int r, int c);
    return r >= rows_active() || c >= cols_active() || written[r][c];
  endfunction

  task automatic send(logic [1:0] m, logic [7:0] r, logic [2:0] c, logic [31:0] v);
    int gap;
    bit ok;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.mode   <= m;
    in_data.row    <= r;
    in_data.column <= c;
    in_data.value  <= v;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    if (m == MODE_WRITE) begin
      written[r][c] = 1'b1;
      shadow[r][c]  = v;
    end
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [2:0] k, logic [8:0] r, logic [3:0] c);
    wait_idle();
    write_reg(CFG_KEY_COLUMN, {6'd0, k});
    write_reg(CFG_ROWS_IN_USE, r);
    write_reg(CFG_COLUMNS_IN_USE, {5'd0, c});
    cur_key  = k;
    cur_rows = r;
    cur_cols = c;
  endtask

  // every column of the rows in use, keys ascending unless scrambled
  task automatic fill_rows(int n, bit ordered, bit narrow);
    logic signed [31:0] kv;
    logic [31:0] v;
    int k;
    k  = key_active();
    kv = narrow ? $signed($urandom_range(0, 2000)) - 1000 : $urandom;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (c == k) v = ordered ? kv : $urandom;
        else v = narrow ? 32'($signed($urandom_range(0, 600)) - 300) : $urandom;
        send(MODE_WRITE, 8'(r), 3'(c), v);
      end
      kv = kv + (narrow ? $urandom_range(0, 40) : $urandom_range(0, 32'h0100_0000));
    end
  endtask

  task automatic random_item(int n);
    int sel;
    int r;
    int c;
    logic [31:0] x;
    sel = $urandom_range(0, 99);
    c = $urandom_range(0, 7);
    if (sel < 40 && n > 0) begin
      r = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
        0, 1: x = shadow[r][key_active()] + 32'($signed($urandom_range(0, 4)) - 2);
        2: x = shadow[r][key_active()] + $urandom_range(0, 32'h0080_0000);
        default: x = $urandom;
      endcase
      send(MODE_INTERP, 8'($urandom), 3'(c), x);
    end else if (sel < 70) begin
      r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n + 1) : $urandom_range(0, 255);
      if (r > 255) r = 255;
      if (!can_read(r, c)) r = 255;
      if (!can_read(r, c)) r = 0;
      if (can_read(r, c)) send(MODE_READ, 8'(r), 3'(c), $urandom);
    end else if (sel < 94) begin
      r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n + 3) : $urandom_range(0, 255);
      if (r > 255) r = 255;
      send(MODE_WRITE, 8'(r), 3'(c), $urandom);
    end else begin
      send(MODE_SORT, 8'($urandom), 3'($urandom), $urandom);
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin : receiver
      int n;
      bit ok;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = burst ? 0 : $urandom_range(0, 8);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        ok = out_valid;
        @(posedge clk);
      end while (!ok);
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int pick;
    int r;
    int c;
    logic [3:0] cols;
    logic [8:0] rows;
    cycles    = 0;
    sent      = 0;
    burst     = 1'b0;
    hold_req  = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    cur_key   = 3'd0;
    cur_rows  = 9'd0;
    cur_cols  = 4'd8;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset
    send(MODE_INTERP, 8'd0, 3'd0, 32'd5);
    send(MODE_READ, 8'd0, 3'd0, 32'd0);
    send(MODE_SORT, 8'd0, 3'd0, 32'd0);

    set_regs(3'd2, 9'd3, 4'd3);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 8; c++) begin
        send(MODE_WRITE, 8'(r), 3'(c),
             (c == 2) ? 32'(($signed(r) - 1) * 32'sh0064_0000) : $urandom);
      end
    end
    send(MODE_WRITE, 8'd1, 3'd0, 32'h7fff_ffff);
    send(MODE_WRITE, 8'd2, 3'd0, 32'h8000_0000);
    send(MODE_INTERP, 8'hff, 3'd0, 32'h8000_0000);
    send(MODE_INTERP, 8'd0, 3'd1, 32'h7fff_ffff);
    send(MODE_INTERP, 8'd0, 3'd0, 32'h0064_0000);
    send(MODE_INTERP, 8'd0, 3'd1, 32'hff9c_0000);
    send(MODE_INTERP, 8'd0, 3'd0, 32'h0032_1234);
    send(MODE_INTERP, 8'd0, 3'd3, 32'd0);
    send(MODE_INTERP, 8'd0, 3'd7, 32'd0);
    send(MODE_READ, 8'd2, 3'd2, 32'd0);
    send(MODE_READ, 8'd3, 3'd0, 32'd0);
    send(MODE_READ, 8'd0, 3'd3, 32'd0);
    // unsorted middle key, then sort
    send(MODE_WRITE, 8'd1, 3'd2, 32'h7000_0000);
    send(MODE_INTERP, 8'd0, 3'd0, 32'h0010_0000);
    send(MODE_SORT, 8'd0, 3'd0, 32'd0);
    send(MODE_INTERP, 8'd0, 3'd0, 32'h0010_0000);
    // key column past the columns in use falls back to column 0
    set_regs(3'd7, 9'd3, 4'd3);
    send(MODE_INTERP, 8'd0, 3'd1, 32'h0000_0001);
    send(MODE_SORT, 8'd0, 3'd0, 32'd0);
    send(MODE_READ, 8'd0, 3'd1, 32'd0);

    phase = 0;
    while (sent < 1700) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: cols = 4'd0;
        1: cols = 4'd15;
        2: cols = 4'd8;
        default: cols = 4'($urandom_range(1, 8));
      endcase
      if (phase == 2 || pick < 6) rows = (pick < 3) ? 9'd511 : 9'd256;
      else if (pick < 12) rows = 9'd0;
      else if (pick < 18) rows = 9'($urandom_range(20, 40));
      else rows = 9'($urandom_range(1, 12));
      set_regs(3'($urandom_range(0, 7)), rows, cols);
      burst = ($urandom_range(0, 4) == 0);
      n = rows_active();
      if (phase == 4) hold_req = 1'b1;
      if (n == 256) begin
        // full-size setting: only writes, and reads of cells already written or outside the columns in use
        for (int i = 0; i < 60; i++) begin
          r = $urandom_range(0, 255);
          c = $urandom_range(0, 7);
          if ($urandom_range(0, 1) == 0 || !can_read(r, c))
            send(MODE_WRITE, 8'(r), 3'(c), $urandom);
          else
            send(MODE_READ, 8'(r), 3'(c), $urandom);
        end
      end else begin
        fill_rows(n, $urandom_range(0, 4) != 0, $urandom_range(0, 1) == 1);
        for (int i = 0; i < 40; i++) random_item(n);
      end
      phase++;
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
